// ----- src/ydrgb_pkg.sv -----
package ydrgb_pkg;

	localparam int LINE_PIXELS    = 640;
	localparam int MACRO_PER_LINE = LINE_PIXELS / 2;
	localparam int COL_W          = $clog2(MACRO_PER_LINE);

	localparam int WORD_W = 32;
	localparam int COEF_W = 29;
	localparam int FRAC_W = 28;
	localparam int PROD_W = COEF_W + 8;

	// fixed-point coefficients, rounded up so the floor of the product matches exact truncation
	localparam logic [COEF_W-1:0] COEF_RV = COEF_W'((64'd1370705 * (64'd1 << FRAC_W)
		+ 64'd999999) / 64'd1000000);
	localparam logic [COEF_W-1:0] COEF_GU = COEF_W'((64'd337633 * (64'd1 << FRAC_W)
		+ 64'd999999) / 64'd1000000);
	localparam logic [COEF_W-1:0] COEF_GV = COEF_W'((64'd698001 * (64'd1 << FRAC_W)
		+ 64'd999999) / 64'd1000000);
	localparam logic [COEF_W-1:0] COEF_BU = COEF_W'((64'd1732446 * (64'd1 << FRAC_W)
		+ 64'd999999) / 64'd1000000);

	localparam logic [7:0] CHROMA_ZERO = 8'd128;
	localparam logic [7:0] MASK_B565   = 8'hF8;
	localparam logic [7:0] MASK_G565   = 8'hFC;

	typedef enum logic [1:0] {
		PH_DIRECT = 2'd0,
		PH_STORE  = 2'd1,
		PH_AVG    = 2'd2
	} phase_t;

	typedef enum logic {
		FMT_RGB888 = 1'b0,
		FMT_RGB565 = 1'b1
	} fmt_t;

	typedef struct packed {
		logic signed [8:0] tr;
		logic signed [8:0] tgu;
		logic signed [8:0] tgv;
		logic signed [8:0] tb;
	} chroma_terms_t;

	function automatic logic signed [8:0] coef_term(input logic [COEF_W-1:0] c,
		input logic [7:0] x);
		logic [7:0]        mag;
		logic [PROD_W-1:0] prod;
		logic [7:0]        q;
		mag  = x[7] ? (x - CHROMA_ZERO) : (CHROMA_ZERO - x);
		prod = PROD_W'(c) * PROD_W'(mag);
		q    = prod[FRAC_W+7:FRAC_W];
		return x[7] ? $signed({1'b0, q}) : -$signed({1'b0, q});
	endfunction

	function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8:1];
	endfunction

	function automatic logic [7:0] clamp8(input logic signed [10:0] v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > 11'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ----- src/ydrgb_ram.sv -----
module ydrgb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 320
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/ydrgb_color.sv -----
module ydrgb_color (
	input  logic [7:0]                    y,
	input  ydrgb_pkg::chroma_terms_t      terms,
	input  ydrgb_pkg::fmt_t               fmt,
	output logic [ydrgb_pkg::WORD_W-1:0]  word
);
	import ydrgb_pkg::*;

	logic signed [10:0] y_s;
	logic signed [10:0] r_s;
	logic signed [10:0] g_s;
	logic signed [10:0] b_s;
	logic [7:0]         r;
	logic [7:0]         g;
	logic [7:0]         b;

	always_comb begin
		y_s  = $signed({3'b000, y});
		r_s  = y_s + $signed({{2{terms.tr[8]}}, terms.tr});
		g_s  = y_s - $signed({{2{terms.tgu[8]}}, terms.tgu})
			- $signed({{2{terms.tgv[8]}}, terms.tgv});
		b_s  = y_s + $signed({{2{terms.tb[8]}}, terms.tb});
		r    = clamp8(r_s);
		g    = clamp8(g_s);
		b    = clamp8(b_s);
		case (fmt)
			FMT_RGB565: word = {16'h0000, b & MASK_B565, 8'h00} |
				{21'd0, g & MASK_G565, 3'b000} | {27'd0, r[7:3]};
			default:    word = {8'h00, b, g, r};
		endcase
	end

endmodule

// ----- src/yuyv_downscale_to_rgb.sv -----
// channel | handshake           | payload                                        | dir
// --------+---------------------+------------------------------------------------+----
// input   | in_valid/in_ready   | y_first u_chroma y_second v_chroma frame_start | in
// output  | out_valid/out_ready | pixel_word row_end last_of_item                | out
// config  | cfg_we              | cfg_wdata (pixel format select)                | in
//
// a macropixel enters when stage 1 is empty or moving on, so a new one can enter while
// the last one's pixels leave; it yields 0, 1 or 2 pixels, one per cycle through the
// output register while out_ready holds; the sustained rate is set by the single output port.
// from accept to out_valid: store read, average and chroma terms, then color pack.
// reset clears position, phase, format and valid bits; the line store needs no clear.
// an output stall backs up through the two stages into in_ready.
module yuyv_downscale_to_rgb (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  y_first,
	input  logic [7:0]  u_chroma,
	input  logic [7:0]  y_second,
	input  logic [7:0]  v_chroma,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pixel_word,
	output logic        row_end,
	output logic        last_of_item
);
	import ydrgb_pkg::*;

	fmt_t             fmt_q;
	logic [COL_W-1:0] col_q;
	phase_t           phase_q;

	logic             accept;
	logic [COL_W-1:0] col_eff;
	phase_t           phase_eff;
	phase_t           phase_nxt;
	logic             last_col;

	logic               ram_we;
	logic               ram_re;
	logic [WORD_W-1:0]  ram_rdata;

	logic             s1_valid_q;
	logic [7:0]       y0_s1;
	logic [7:0]       u_s1;
	logic [7:0]       y1_s1;
	logic [7:0]       v_s1;
	logic             odd_s1;
	logic             last_s1;
	phase_t           phase_s1;

	logic [7:0]       ya_c;
	logic [7:0]       yb_c;
	logic [7:0]       uu_c;
	logic [7:0]       vv_c;
	logic             s1_has;
	logic             s1_go;
	chroma_terms_t    terms_c;

	logic             s2_valid_q;
	logic [7:0]       ya_s2;
	logic [7:0]       yb_s2;
	chroma_terms_t    terms_s2;
	logic             two_s2;
	logic             last_s2;
	logic             sel_q;

	logic             is_last;
	logic             out_free;
	logic             emit;
	logic             s2_done;
	logic             s2_free;
	logic [7:0]       y_pix;
	logic [WORD_W-1:0] word_c;

	logic             out_valid_q;
	logic [31:0]      pixel_q;
	logic             row_end_q;
	logic             last_q;

	// position and phase of the incoming transaction
	always_comb begin
		accept    = in_valid && in_ready;
		col_eff   = frame_start ? '0 : col_q;
		phase_eff = frame_start ? PH_DIRECT : phase_q;
		last_col  = (col_eff == COL_W'(MACRO_PER_LINE - 1));
		case (phase_eff)
			PH_DIRECT: phase_nxt = PH_STORE;
			PH_STORE:  phase_nxt = PH_AVG;
			default:   phase_nxt = PH_DIRECT;
		endcase
		ram_we = accept && (phase_eff == PH_STORE);
		ram_re = accept && (phase_eff == PH_AVG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_RGB888;
			col_q   <= '0;
			phase_q <= PH_DIRECT;
		end else begin
			if (cfg_we) begin
				fmt_q <= fmt_t'(cfg_wdata);
			end
			if (accept) begin
				if (last_col) begin
					col_q   <= '0;
					phase_q <= phase_nxt;
				end else begin
					col_q   <= col_eff + 1'b1;
					phase_q <= phase_eff;
				end
			end
		end
	end

	ydrgb_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MACRO_PER_LINE)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_eff),
		.wdata({v_chroma, y_second, u_chroma, y_first}),
		.re   (ram_re),
		.raddr(col_eff),
		.rdata(ram_rdata)
	);

	// stage 1: store read data, averaging and chroma terms
	always_comb begin
		s1_has = (phase_s1 != PH_STORE);
		if (phase_s1 == PH_AVG) begin
			uu_c = avg8(ram_rdata[15:8], u_s1);
			vv_c = avg8(ram_rdata[31:24], v_s1);
			yb_c = avg8(ram_rdata[23:16], y1_s1);
			ya_c = odd_s1 ? avg8(ram_rdata[7:0], y1_s1) : avg8(ram_rdata[7:0], y0_s1);
		end else begin
			uu_c = u_s1;
			vv_c = v_s1;
			yb_c = y1_s1;
			ya_c = odd_s1 ? avg8(y0_s1, y1_s1) : y0_s1;
		end
		terms_c.tr  = coef_term(COEF_RV, vv_c);
		terms_c.tgu = coef_term(COEF_GU, uu_c);
		terms_c.tgv = coef_term(COEF_GV, vv_c);
		terms_c.tb  = coef_term(COEF_BU, uu_c);
	end

	// stage 2 and output register handshake
	always_comb begin
		is_last  = !two_s2 || sel_q;
		out_free = !out_valid_q || out_ready;
		emit     = s2_valid_q && out_free;
		s2_done  = emit && is_last;
		s2_free  = !s2_valid_q || s2_done;
		s1_go    = s1_valid_q && (!s1_has || s2_free);
		in_ready = !s1_valid_q || s1_go;
		y_pix    = sel_q ? yb_s2 : ya_s2;
	end

	ydrgb_color u_color (
		.y    (y_pix),
		.terms(terms_s2),
		.fmt  (fmt_q),
		.word (word_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go && s1_has) begin
				s2_valid_q <= 1'b1;
			end else if (s2_done) begin
				s2_valid_q <= 1'b0;
			end
			if (emit) begin
				sel_q <= !is_last;
			end
			if (out_free) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y0_s1    <= y_first;
			u_s1     <= u_chroma;
			y1_s1    <= y_second;
			v_s1     <= v_chroma;
			odd_s1   <= col_eff[0];
			last_s1  <= last_col;
			phase_s1 <= phase_eff;
		end
		if (s1_go && s1_has) begin
			ya_s2    <= ya_c;
			yb_s2    <= yb_c;
			terms_s2 <= terms_c;
			two_s2   <= !odd_s1;
			last_s2  <= last_s1;
		end
		if (emit) begin
			pixel_q   <= word_c;
			row_end_q <= is_last && last_s2;
			last_q    <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_word   = pixel_q;
	assign row_end      = row_end_q;
	assign last_of_item = last_q;

endmodule

// ----- dv/yuyv_downscale_to_rgb_tb.sv -----
`timescale 1ns / 1ps

module yuyv_downscale_to_rgb_tb;
	import ydrgb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE      = 12;
	localparam int DIR_ROWS    = 16;

	typedef struct packed {
		logic [7:0]  y0;
		logic [7:0]  u;
		logic [7:0]  y1;
		logic [7:0]  v;
		logic        fs;
		logic        typed;
		logic [1:0]  n;
		logic [31:0] w0;
		logic [31:0] w1;
	} stim_row_t;

	typedef struct {
		logic [31:0] word;
		logic        row_end;
		logic        item_end;
	} pixel_due_t;

	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{8'h00, 8'h80, 8'hFF, 8'h80, 1'b1, 1'b1, 2'd2, 32'h00000000, 32'h00FFFFFF},
		'{8'hFF, 8'h80, 8'hFF, 8'h80, 1'b0, 1'b1, 2'd1, 32'h00FFFFFF, 32'h0},
		'{8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'h80, 8'h80, 8'h80, 8'h80, 1'b1, 1'b1, 2'd2, 32'h00808080, 32'h00808080},
		'{8'h00, 8'h80, 8'hFF, 8'h80, 1'b0, 1'b1, 2'd1, 32'h007F7F7F, 32'h0},
		'{8'h01, 8'h7F, 8'h02, 8'h81, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'hFE, 8'h01, 8'hFD, 8'hFE, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'h7F, 8'h80, 8'h80, 8'h7F, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
		'{8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0}
	};

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_we      = 1'b0;
	logic        cfg_wdata   = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  y_first     = 8'h00;
	logic [7:0]  u_chroma    = 8'h00;
	logic [7:0]  y_second    = 8'h00;
	logic [7:0]  v_chroma    = 8'h00;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [31:0] pixel_word;
	logic        row_end;
	logic        last_of_item;

	pixel_due_t  pending_pixels [$];
	pixel_due_t  head_px;
	logic [31:0] row_mem [MACRO_PER_LINE];
	int          col_pos     = 0;
	phase_t      row_phase   = PH_DIRECT;
	fmt_t        out_fmt     = FMT_RGB888;
	int          fail_count  = 0;
	int          cycle_count = 0;
	int          sent_count  = 0;
	bit          quiet       = 1'b0;
	bit          hold_req    = 1'b0;

	yuyv_downscale_to_rgb dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.y_first     (y_first),
		.u_chroma    (u_chroma),
		.y_second    (y_second),
		.v_chroma    (v_chroma),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_word  (pixel_word),
		.row_end     (row_end),
		.last_of_item(last_of_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int chroma_term(int c, logic [7:0] x);
		int d;
		d = int'(x) - 128;
		return (c * d) / 1000000;
	endfunction

	function automatic logic [7:0] clip(int val);
		if (val < 0) begin
			return 8'd0;
		end
		if (val > 255) begin
			return 8'd255;
		end
		return 8'(val);
	endfunction

	function automatic logic [7:0] halve(int a, int b);
		return 8'((a + b) / 2);
	endfunction

	function automatic logic [31:0] rgb_pack(logic [7:0] y, logic [7:0] u, logic [7:0] v);
		logic [7:0] r, g, b;
		r = clip(int'(y) + chroma_term(1370705, v));
		g = clip(int'(y) - chroma_term(337633, u) - chroma_term(698001, v));
		b = clip(int'(y) + chroma_term(1732446, u));
		if (out_fmt == FMT_RGB565) begin
			return {16'h0000, b[7:3], g[7:2], r[7:3]};
		end
		return {8'h00, b, g, r};
	endfunction

	task automatic scale_macropixel(input logic [7:0] y0, u, y1, v, input logic fs,
		output int n, output logic [1:0][31:0] px, output logic line_done);
		logic [7:0] sy0, su, sy1, sv, au, av;
		if (fs) begin
			col_pos   = 0;
			row_phase = PH_DIRECT;
		end
		line_done = (col_pos == MACRO_PER_LINE - 1);
		n  = 0;
		px = '0;
		case (row_phase)
			PH_STORE: begin
				row_mem[col_pos] = {v, y1, u, y0};
			end
			PH_AVG: begin
				{sv, sy1, su, sy0} = row_mem[col_pos];
				au = halve(su, u);
				av = halve(sv, v);
				if (col_pos % 2 == 1) begin
					px[0] = rgb_pack(halve(sy0, y1), au, av);
					n = 1;
				end else begin
					px[0] = rgb_pack(halve(sy0, y0), au, av);
					px[1] = rgb_pack(halve(sy1, y1), au, av);
					n = 2;
				end
			end
			default: begin
				if (col_pos % 2 == 1) begin
					px[0] = rgb_pack(halve(y0, y1), u, v);
					n = 1;
				end else begin
					px[0] = rgb_pack(y0, u, v);
					px[1] = rgb_pack(y1, u, v);
					n = 2;
				end
			end
		endcase
		if (line_done) begin
			col_pos   = 0;
			row_phase = (row_phase == PH_AVG) ? PH_DIRECT : phase_t'(row_phase + 1);
		end else begin
			col_pos++;
		end
	endtask

	task automatic push_pixels(input int n, input logic [1:0][31:0] px, input logic line_done);
		pixel_due_t e;
		for (int k = 0; k < n; k++) begin
			e.word     = px[k];
			e.item_end = (k == n - 1);
			e.row_end  = (k == n - 1) && line_done;
			pending_pixels.push_back(e);
		end
	endtask

	task automatic transfer(input logic [7:0] a, b, c, d, input logic fs);
		int gap;
		@(negedge clk);
		if (!quiet && (sent_count % 64) < 40 && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		y_first     <= a;
		u_chroma    <= b;
		y_second    <= c;
		v_chroma    <= d;
		frame_start <= fs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	task automatic drain(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_format(input fmt_t f);
		drain(SETTLE);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= f;
		@(negedge clk);
		cfg_we    <= 1'b0;
		out_fmt = f;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random(input int count, input logic first_fs, input int restart_odds);
		logic [7:0]       a, b, c, d;
		logic             fs;
		int               n;
		logic [1:0][31:0] px;
		logic             line_done;
		for (int i = 0; i < count; i++) begin
			a  = rand_byte();
			b  = rand_byte();
			c  = rand_byte();
			d  = rand_byte();
			fs = (i == 0 && first_fs) ||
				(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
			transfer(a, b, c, d, fs);
			scale_macropixel(a, b, c, d, fs, n, px, line_done);
			push_pixels(n, px, line_done);
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %h actual %h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel_word expected none actual %h", pixel_word);
				fail_count++;
			end else begin
				head_px = pending_pixels.pop_front();
				check_field("pixel_word", head_px.word, pixel_word);
				check_field("row_end", 32'(head_px.row_end), 32'(row_end));
				check_field("last_of_item", 32'(head_px.item_end), 32'(last_of_item));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
				out_ready <= 1'b1;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 10);
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	initial begin
		stim_row_t        row;
		int               n;
		logic [1:0][31:0] px;
		logic             line_done;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			transfer(row.y0, row.u, row.y1, row.v, row.fs);
			scale_macropixel(row.y0, row.u, row.y1, row.v, row.fs, n, px, line_done);
			if (row.typed) begin
				n     = row.n;
				px[0] = row.w0;
				px[1] = row.w1;
			end
			push_pixels(n, px, line_done);
		end

		// full frame: direct line under a long output stall, stored line, averaged line
		set_format(FMT_RGB565);
		hold_req = 1'b1;
		send_random(MACRO_PER_LINE, 1'b1, 0);
		set_format(FMT_RGB888);
		send_random(MACRO_PER_LINE, 1'b0, 0);
		drain(SETTLE);
		send_random(MACRO_PER_LINE / 2, 1'b0, 0);
		set_format(FMT_RGB565);
		send_random(MACRO_PER_LINE / 2, 1'b0, 0);

		// restarts at random points in the line
		set_format(FMT_RGB888);
		send_random(240, 1'b0, 40);
		set_format(FMT_RGB565);
		quiet = 1'b1;
		send_random(100, 1'b0, 40);

		drain(20);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- yuyv_downscale_to_rgb.f -----
src/ydrgb_pkg.sv
src/ydrgb_ram.sv
src/ydrgb_color.sv
src/yuyv_downscale_to_rgb.sv
dv/yuyv_downscale_to_rgb_tb.sv
